### sv/sbbr_pkg.sv
// Shared types and constants for the sliding box blur row filter.
// No dependencies; the config interface, lane, merge and top files refer to it by scoped names.
`timescale 1ns / 1ps

package sbbr_pkg;

    // Configuration register map
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIUS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECIP  = 1'b1;

    localparam int RADIUS_W = 5;
    localparam int RECIP_W  = 17;
    localparam int CFG_DATA_W = 17;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 5'd1;
    localparam logic [RECIP_W-1:0]  RECIP_RESET  = 17'd21845;

    // Window length 2r+1 fits six bits for any five-bit radius
    localparam int N_W = RADIUS_W + 1;
    // Guard bits of a running sum over at most 63 pixels
    localparam int SUM_GUARD = 6;

    // Scaling: 1.16 reciprocal, round half up
    localparam int FRAC_BITS = 16;
    localparam int ROUND_HALF = 32768;

    // Sequencer states
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_ACC   = 5'b00010,
        S_SCALE = 5'b00100,
        S_OUT   = 5'b01000,
        S_TREAD = 5'b10000
    } state_t;

    // Controls from the sequencer to each channel lane
    typedef struct packed {
        logic acc_en;
        logic first;
        logic use_edge;
        logic scale_en;
    } lane_ctrl_t;

    // Controls from the sequencer to the output merge stage
    typedef struct packed {
        logic load;
        logic err;
        logic last;
    } merge_ctrl_t;

endpackage

### sv/sbbr_pix_if.sv
// Pixel request channel: valid/ready handshake with RGB payload and row end mark.
// Depends on nothing; width set by its parameter.
`timescale 1ns / 1ps

interface sbbr_pix_if #(
    parameter int CHANNEL_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] red;
    logic [CHANNEL_BITS-1:0] green;
    logic [CHANNEL_BITS-1:0] blue;
    logic                    row_end;

    modport source (output valid, red, green, blue, row_end, input ready);
    modport sink   (input valid, red, green, blue, row_end, output ready);
endinterface

### sv/sbbr_res_if.sv
// Result request channel: valid/ready handshake with blurred RGB and status flags.
// Depends on nothing; width set by its parameter.
`timescale 1ns / 1ps

interface sbbr_res_if #(
    parameter int CHANNEL_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [CHANNEL_BITS-1:0] out_red;
    logic [CHANNEL_BITS-1:0] out_green;
    logic [CHANNEL_BITS-1:0] out_blue;
    logic                    run_last;
    logic                    short_row;

    modport source (output valid, out_red, out_green, out_blue, run_last, short_row,
                    input ready);
    modport sink   (input valid, out_red, out_green, out_blue, run_last, short_row,
                    output ready);
endinterface

### sv/sbbr_cfg_if.sv
// Configuration write channel: valid/ready handshake, register index and data.
// Depends on sbbr_pkg for the index and data widths.
`timescale 1ns / 1ps

interface sbbr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sbbr_pkg::CFG_IDX_W-1:0]    index;
    logic [sbbr_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### sv/sbbr_window.sv
// Pixel delay line memory: one write port, one read port with registered data.
// Depends on nothing.
`timescale 1ns / 1ps

module sbbr_window #(
    parameter int DEPTH = 63,
    parameter int WIDTH = 48,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Read returns the old entry when the same address is written
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/sbbr_lane.sv
// One color channel: running window sum, row edge pixel, reciprocal scaling.
// Depends on sbbr_pkg for the lane control struct and scaling constants.
`timescale 1ns / 1ps

module sbbr_lane #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  sbbr_pkg::lane_ctrl_t           ctrl,
    input  logic [sbbr_pkg::N_W-1:0]       win_len,
    input  logic [sbbr_pkg::RECIP_W-1:0]   recip,
    input  logic [CHANNEL_BITS-1:0]        px,
    input  logic [CHANNEL_BITS-1:0]        old_px,
    output logic [CHANNEL_BITS-1:0]        value
);

    localparam int SW = CHANNEL_BITS + sbbr_pkg::SUM_GUARD;
    localparam int PW = SW + sbbr_pkg::RECIP_W;
    localparam int VW = PW - sbbr_pkg::FRAC_BITS;

    logic [SW-1:0]           sum_reg;
    logic [SW-1:0]           sum_next;
    logic [CHANNEL_BITS-1:0] edge_reg;
    logic [PW-1:0]           prod_reg;
    logic [CHANNEL_BITS-1:0] leaving;
    logic [PW-1:0]           rounded;
    logic [VW-1:0]           scaled;

    // Pick the pixel leaving the window: left edge copy or delay line
    assign leaving = ctrl.use_edge ? edge_reg : old_px;

    // Seed the sum with the row's first pixel, else slide it by one
    always_comb
    begin
        if (ctrl.first)
        begin
            sum_next = SW'(win_len) * SW'(px);
        end
        else
        begin
            sum_next = sum_reg + SW'(px) - SW'(leaving);
        end
    end

    // Hold the sum and the edge pixel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg  <= '0;
            edge_reg <= '0;
        end
        else if (ctrl.acc_en)
        begin
            sum_reg <= sum_next;
            if (ctrl.first)
            begin
                edge_reg <= px;
            end
        end
    end

    // Multiply by the reciprocal
    always_ff @(posedge clk)
    begin
        if (ctrl.scale_en)
        begin
            prod_reg <= PW'(sum_reg) * PW'(recip);
        end
    end

    // Round half up, drop the fraction, saturate
    assign rounded = prod_reg + PW'(sbbr_pkg::ROUND_HALF);
    assign scaled  = rounded[PW-1:sbbr_pkg::FRAC_BITS];
    assign value   = (|scaled[VW-1:CHANNEL_BITS]) ? {CHANNEL_BITS{1'b1}}
                                                  : scaled[CHANNEL_BITS-1:0];

endmodule

### sv/sbbr_merge.sv
// Output stage: merges the three lane results and flags into one result register.
// Depends on sbbr_pkg for the merge control struct and on sbbr_res_if.
`timescale 1ns / 1ps

module sbbr_merge #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  sbbr_pkg::merge_ctrl_t   ctrl,
    input  logic [CHANNEL_BITS-1:0] red,
    input  logic [CHANNEL_BITS-1:0] green,
    input  logic [CHANNEL_BITS-1:0] blue,
    output logic                    slot_free,
    sbbr_res_if.source              res
);

    logic                    valid_reg;
    logic [CHANNEL_BITS-1:0] red_reg;
    logic [CHANNEL_BITS-1:0] green_reg;
    logic [CHANNEL_BITS-1:0] blue_reg;
    logic                    last_reg;
    logic                    short_reg;

    assign slot_free = !valid_reg || res.ready;

    // Hold the request until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.load)
        begin
            valid_reg <= 1'b1;
        end
        else if (res.ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    // Load the payload; a short row reports zeros
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            red_reg   <= ctrl.err ? '0 : red;
            green_reg <= ctrl.err ? '0 : green;
            blue_reg  <= ctrl.err ? '0 : blue;
            last_reg  <= ctrl.last;
            short_reg <= ctrl.err;
        end
    end

    assign res.valid     = valid_reg;
    assign res.out_red   = red_reg;
    assign res.out_green = green_reg;
    assign res.out_blue  = blue_reg;
    assign res.run_last  = last_reg;
    assign res.short_row = short_reg;

endmodule

### sv/sliding_box_blur_row_top.sv
// Top level of the horizontal running-sum box blur: sequencer, config, lanes.
// Depends on sbbr_pkg, the three channel interfaces, sbbr_window, sbbr_lane, sbbr_merge.
`timescale 1ns / 1ps

// Horizontal box blur over one RGB row stream. Each pixel is taken in one
// request; output j leaves once pixel j+r is in, and the row's last pixel
// (or the MAX_ROW_WIDTH-th) brings out the remaining r+1 outputs with
// run_last on the final one; a pixel with a single result sets run_last on
// it. Pixels past either row edge repeat the first or last pixel. A row
// shorter than 2r+1 ends with one result flagged short_row. Each blurred
// result passes through a delay line read, a sum update, a reciprocal
// multiply and an output load, which waits while the result register is
// full and not taken; a row end holds the input until all its results are
// loaded. The result register lets the next pixel enter while a result
// still waits. Three channel lanes run side by side. No clearing pass
// follows reset. Configuration writes: index 0 radius, index 1 reciprocal.
module sliding_box_blur_row_top #(
    parameter int MAX_RADIUS    = 31,
    parameter int MAX_ROW_WIDTH = 4096,
    parameter int CHANNEL_BITS  = 16
) (
    input  logic      clk,
    input  logic      rst_n,
    sbbr_pix_if.sink  pix,
    sbbr_res_if.source res,
    sbbr_cfg_if.sink  cfg
);

    localparam int DEPTH = 2 * MAX_RADIUS + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(MAX_ROW_WIDTH);
    localparam int KW    = CW + 1;
    localparam int PXW   = 3 * CHANNEL_BITS;
    localparam int RW    = sbbr_pkg::RADIUS_W;
    localparam int NW    = sbbr_pkg::N_W;

    // Configuration registers
    logic [RW-1:0]                radius_reg;
    logic [sbbr_pkg::RECIP_W-1:0] recip_reg;

    // Sequencer state
    sbbr_pkg::state_t state_reg, state_next;
    logic [CW-1:0]    col_reg, col_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic signed [KW-1:0] k_reg, k_next;
    logic [RW-1:0]    t_reg, t_next;
    logic             first_reg, first_next;
    logic             end_reg, end_next;
    logic             err_reg, err_next;
    logic             emit_reg, emit_next;
    logic [PXW-1:0]   px_reg;

    logic             accept;
    logic [RW-1:0]    r_eff;
    logic [NW-1:0]    win_len;
    logic [AW:0]      wp_ext;
    logic [AW:0]      n_ext;
    logic [AW-1:0]    rp_first;
    logic [AW-1:0]    raddr;
    logic [PXW-1:0]   pix_word;
    logic [PXW-1:0]   old_word;
    logic             row_done;
    logic             slot_free;
    logic             last_now;

    sbbr_pkg::lane_ctrl_t  lane_ctrl;
    sbbr_pkg::merge_ctrl_t merge_ctrl;

    logic [CHANNEL_BITS-1:0] val_red;
    logic [CHANNEL_BITS-1:0] val_green;
    logic [CHANNEL_BITS-1:0] val_blue;

    // Take configuration writes at any time
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= sbbr_pkg::RADIUS_RESET;
            recip_reg  <= sbbr_pkg::RECIP_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                sbbr_pkg::CFG_RADIUS: radius_reg <= cfg.data[RW-1:0];
                sbbr_pkg::CFG_RECIP:  recip_reg  <= cfg.data[sbbr_pkg::RECIP_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the radius and form the window length 2r+1
    assign r_eff   = (32'(radius_reg) > MAX_RADIUS) ? RW'(MAX_RADIUS) : radius_reg;
    assign win_len = {r_eff, 1'b1};

    // Oldest window slot: write slot minus window length, modulo the depth
    assign wp_ext   = (AW+1)'(wp_reg);
    assign n_ext    = (AW+1)'(win_len);
    assign rp_first = (wp_ext >= n_ext) ? AW'(wp_ext - n_ext)
                                        : AW'(wp_ext + (AW+1)'(DEPTH) - n_ext);

    assign pix.ready = (state_reg == sbbr_pkg::S_IDLE);
    assign accept    = pix.valid && pix.ready;
    assign pix_word  = {pix.blue, pix.green, pix.red};
    assign row_done  = pix.row_end || (col_reg == CW'(MAX_ROW_WIDTH - 1));
    assign last_now  = err_reg || !end_reg || (t_reg == r_eff);
    assign raddr     = (state_reg == sbbr_pkg::S_IDLE) ? rp_first : rp_reg;

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        col_next   = col_reg;
        wp_next    = wp_reg;
        rp_next    = rp_reg;
        k_next     = k_reg;
        t_next     = t_reg;
        first_next = first_reg;
        end_next   = end_reg;
        err_next   = err_reg;
        emit_next  = emit_reg;
        merge_ctrl = '0;
        case (state_reg)
            sbbr_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    first_next = (col_reg == '0);
                    end_next   = row_done;
                    err_next   = row_done &&
                                 (({1'b0, col_reg} + (CW+1)'(1)) < (CW+1)'(win_len));
                    emit_next  = (col_reg >= CW'(r_eff));
                    col_next   = row_done ? '0 : col_reg + CW'(1);
                    wp_next    = row_done ? '0 :
                                 ((wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + AW'(1));
                    rp_next    = (rp_first == AW'(DEPTH - 1)) ? '0 : rp_first + AW'(1);
                    k_next     = $signed({1'b0, col_reg}) - $signed(KW'(win_len));
                    t_next     = '0;
                    state_next = sbbr_pkg::S_ACC;
                end
            end
            sbbr_pkg::S_ACC:
            begin
                first_next = 1'b0;
                if (err_reg)
                begin
                    state_next = sbbr_pkg::S_OUT;
                end
                else if (emit_reg)
                begin
                    state_next = sbbr_pkg::S_SCALE;
                end
                else
                begin
                    state_next = sbbr_pkg::S_IDLE;
                end
            end
            sbbr_pkg::S_SCALE:
            begin
                state_next = sbbr_pkg::S_OUT;
            end
            sbbr_pkg::S_OUT:
            begin
                if (slot_free)
                begin
                    merge_ctrl.load = 1'b1;
                    merge_ctrl.err  = err_reg;
                    merge_ctrl.last = last_now;
                    if (last_now)
                    begin
                        state_next = sbbr_pkg::S_IDLE;
                    end
                    else
                    begin
                        t_next     = t_reg + RW'(1);
                        state_next = sbbr_pkg::S_TREAD;
                    end
                end
            end
            sbbr_pkg::S_TREAD:
            begin
                rp_next    = (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + AW'(1);
                k_next     = k_reg + KW'(1);
                state_next = sbbr_pkg::S_ACC;
            end
            default:
            begin
                state_next = sbbr_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sbbr_pkg::S_IDLE;
            col_reg   <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
            k_reg     <= '0;
            t_reg     <= '0;
            first_reg <= 1'b0;
            end_reg   <= 1'b0;
            err_reg   <= 1'b0;
            emit_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            col_reg   <= col_next;
            wp_reg    <= wp_next;
            rp_reg    <= rp_next;
            k_reg     <= k_next;
            t_reg     <= t_next;
            first_reg <= first_next;
            end_reg   <= end_next;
            err_reg   <= err_next;
            emit_reg  <= emit_next;
        end
    end

    // Hold the accepted pixel for the tail
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            px_reg <= pix_word;
        end
    end

    // Delay line of the last 2*MAX_RADIUS+1 pixels
    sbbr_window #(
        .DEPTH (DEPTH),
        .WIDTH (PXW),
        .AW    (AW)
    ) u_window (
        .clk   (clk),
        .we    (accept),
        .waddr (wp_reg),
        .wdata (pix_word),
        .re    (accept || (state_reg == sbbr_pkg::S_TREAD)),
        .raddr (raddr),
        .rdata (old_word)
    );

    // Drive the lanes
    always_comb
    begin
        lane_ctrl.acc_en   = (state_reg == sbbr_pkg::S_ACC);
        lane_ctrl.first    = first_reg;
        lane_ctrl.use_edge = k_reg[KW-1] || (k_reg == '0);
        lane_ctrl.scale_en = (state_reg == sbbr_pkg::S_SCALE);
    end

    sbbr_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_red (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .win_len (win_len),
        .recip   (recip_reg),
        .px      (px_reg[CHANNEL_BITS-1:0]),
        .old_px  (old_word[CHANNEL_BITS-1:0]),
        .value   (val_red)
    );

    sbbr_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_green (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .win_len (win_len),
        .recip   (recip_reg),
        .px      (px_reg[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .old_px  (old_word[2*CHANNEL_BITS-1:CHANNEL_BITS]),
        .value   (val_green)
    );

    sbbr_lane #(.CHANNEL_BITS(CHANNEL_BITS)) u_lane_blue (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (lane_ctrl),
        .win_len (win_len),
        .recip   (recip_reg),
        .px      (px_reg[PXW-1:2*CHANNEL_BITS]),
        .old_px  (old_word[PXW-1:2*CHANNEL_BITS]),
        .value   (val_blue)
    );

    // Merge the lanes into the result register
    sbbr_merge #(.CHANNEL_BITS(CHANNEL_BITS)) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (merge_ctrl),
        .red       (val_red),
        .green     (val_green),
        .blue      (val_blue),
        .slot_free (slot_free),
        .res       (res)
    );

endmodule
